// ----- rtl/led_blink_shift_driver_core_assert.svh -----
// ----------------------------------------------------------------------------
// led_blink_shift_driver_core_assert
// assertion macros shared by the led blink shift driver
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_SHIFT_DRIVER_CORE_ASSERT_SVH
`define LED_BLINK_SHIFT_DRIVER_CORE_ASSERT_SVH

// same-cycle implication
`define LBSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// lbsd_pkg
// shared types and constants of the led blink shift driver
// ----------------------------------------------------------------------------
package lbsd_pkg;

    localparam int LBSD_NUM_LEDS    = 16;
    localparam int LBSD_PAT_W       = 16;
    localparam int LBSD_IDX_W       = 4;
    localparam int LBSD_ACT_W       = 3;
    localparam int LBSD_CNT_W       = 3;
    localparam int LBSD_QUEUE_DEPTH = 2;
    localparam int LBSD_OUT_DATA_W  = 8;

    typedef enum logic [LBSD_ACT_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_ON     = 3'd1,
        ACT_OFF    = 3'd2,
        ACT_TOGGLE = 3'd3,
        ACT_SLOW   = 3'd4,
        ACT_FAST   = 3'd5
    } t_action;

    localparam logic [LBSD_CNT_W-1:0] CNT_SLOW_ON  = 3'd0;
    localparam logic [LBSD_CNT_W-1:0] CNT_SLOW_OFF = 3'd4;

    typedef struct packed {
        logic                  valid;
        logic [LBSD_PAT_W-1:0] pattern;
    } t_frame_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ----- rtl/lbsd_front.sv -----
// ----------------------------------------------------------------------------
// lbsd_front
// command decode, mask and pattern state, frame requests to the queue
// ----------------------------------------------------------------------------
module lbsd_front #(
    parameter int NUM_LEDS = lbsd_pkg::LBSD_NUM_LEDS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [lbsd_pkg::LBSD_PAT_W-1:0]       i_s_tdata,   // led_mask
    input  logic [lbsd_pkg::LBSD_ACT_W-1:0]       i_s_tuser,   // action
    input  lbsd_pkg::t_queue_stat                 i_q_stat,
    output lbsd_pkg::t_frame_req                  o_req
);
    import lbsd_pkg::*;

    localparam int FRAME_LEN = (NUM_LEDS > LBSD_PAT_W) ? LBSD_PAT_W : NUM_LEDS;
    localparam logic [LBSD_PAT_W-1:0] LED_BITS = (FRAME_LEN >= LBSD_PAT_W) ?
        {LBSD_PAT_W{1'b1}} : LBSD_PAT_W'((LBSD_PAT_W+1)'(1) << FRAME_LEN) - 1'b1;

    logic [LBSD_PAT_W-1:0] r_on, r_slow, r_fast, r_pat;
    logic [LBSD_PAT_W-1:0] n_on, n_slow, n_fast, n_pat;
    logic [LBSD_CNT_W-1:0] r_cnt, n_cnt;
    logic [LBSD_PAT_W-1:0] m, nm, slow_bits, tick_pat;
    logic                  accept, push;

    assign o_s_tready = !i_q_stat.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign m          = i_s_tdata & LED_BITS;
    assign nm         = ~m;

    always_comb begin
        n_cnt = r_cnt + 1'b1;
        if (n_cnt == CNT_SLOW_ON) begin
            slow_bits = r_slow;
        end else if (n_cnt == CNT_SLOW_OFF) begin
            slow_bits = '0;
        end else begin
            slow_bits = r_slow & r_pat;
        end
        tick_pat = (r_on | slow_bits | (n_cnt[0] ? '0 : r_fast)) & LED_BITS;
    end

    always_comb begin
        n_on   = r_on;
        n_slow = r_slow;
        n_fast = r_fast;
        n_pat  = r_pat;
        push   = 1'b0;
        unique case (t_action'(i_s_tuser))
            ACT_TICK: begin
                n_pat = tick_pat;
                push  = (tick_pat != r_pat);
            end
            ACT_ON: begin
                n_pat  = r_pat | m;
                n_on   = r_on | m;
                n_slow = r_slow & nm;
                n_fast = r_fast & nm;
                push   = 1'b1;
            end
            ACT_OFF: begin
                n_pat  = r_pat & nm;
                n_on   = r_on & nm;
                n_slow = r_slow & nm;
                n_fast = r_fast & nm;
                push   = 1'b1;
            end
            ACT_TOGGLE: begin
                n_pat  = r_pat ^ m;
                n_on   = r_on ^ m;
                n_slow = r_slow & nm;
                n_fast = r_fast & nm;
                push   = 1'b1;
            end
            ACT_SLOW: begin
                n_slow = r_slow | m;
                n_fast = r_fast & nm;
                n_on   = r_on & nm;
            end
            ACT_FAST: begin
                n_fast = r_fast | m;
                n_slow = r_slow & nm;
                n_on   = r_on & nm;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= '0;
            r_slow <= '0;
            r_fast <= '0;
            r_pat  <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_on   <= n_on;
            r_slow <= n_slow;
            r_fast <= n_fast;
            r_pat  <= n_pat;
            if (t_action'(i_s_tuser) == ACT_TICK) begin
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_req.valid   = accept && push;
    assign o_req.pattern = n_pat;

endmodule

// ----- rtl/lbsd_queue.sv -----
// ----------------------------------------------------------------------------
// lbsd_queue
// short fifo of frame patterns between front and shifter
// ----------------------------------------------------------------------------
module lbsd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lbsd_pkg::t_frame_req  i_push,
    input  logic                  i_pop,
    output lbsd_pkg::t_frame_req  o_head,
    output lbsd_pkg::t_queue_stat o_stat
);
    import lbsd_pkg::*;

    localparam int PTR_W = (LBSD_QUEUE_DEPTH > 1) ? $clog2(LBSD_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(LBSD_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LBSD_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LBSD_QUEUE_DEPTH);

    logic [LBSD_PAT_W-1:0] r_mem [LBSD_QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr, r_rd;
    logic [CNT_W-1:0]      r_cnt;
    logic                  do_push, do_pop;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.pattern;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid   = !o_stat.empty;
    assign o_head.pattern = r_mem[r_rd];

endmodule

// ----- rtl/lbsd_shifter.sv -----
// ----------------------------------------------------------------------------
// lbsd_shifter
// serializes one pattern per frame, active low, led 0 first
// ----------------------------------------------------------------------------
module lbsd_shifter #(
    parameter int NUM_LEDS = lbsd_pkg::LBSD_NUM_LEDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lbsd_pkg::t_frame_req                i_head,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lbsd_pkg::LBSD_OUT_DATA_W-1:0] o_m_tdata,  // serial_data, bit_index
    output logic                                o_m_tlast   // latch_last
);
    import lbsd_pkg::*;

    localparam int FRAME_LEN = (NUM_LEDS > LBSD_PAT_W) ? LBSD_PAT_W : NUM_LEDS;
    localparam logic [LBSD_IDX_W-1:0] LAST_IDX = LBSD_IDX_W'(FRAME_LEN - 1);

    logic [LBSD_PAT_W-1:0] r_pat;
    logic [LBSD_IDX_W-1:0] r_idx;
    logic                  r_busy;
    logic                  last, load;

    assign last  = (r_idx == LAST_IDX);
    assign load  = i_head.valid && (!r_busy || (i_m_tready && last));
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_pat  <= i_head.pattern;
        end else if (r_busy && i_m_tready) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {{(LBSD_OUT_DATA_W-LBSD_IDX_W-1){1'b0}}, r_idx, ~r_pat[r_idx]};
    assign o_m_tlast  = last;

endmodule

// ----- rtl/led_blink_shift_driver_core.sv -----
// a frame's first word is valid once the shifter loads the queue entry written by its command
// throughput: one word per cycle while i_m_tready is high, shifter frames of min(NUM_LEDS,16) words
// commands are taken one per cycle while the two-entry frame queue has room
// reset: synchronous active low, clears masks, pattern, tick count, queue and shifter
// ----------------------------------------------------------------------------
// led_blink_shift_driver_core
// led blink controller with serial shift register output
// ----------------------------------------------------------------------------
`include "led_blink_shift_driver_core_assert.svh"

module led_blink_shift_driver_core #(
    parameter int NUM_LEDS = lbsd_pkg::LBSD_NUM_LEDS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [lbsd_pkg::LBSD_PAT_W-1:0]      i_s_tdata,   // led_mask
    input  logic [lbsd_pkg::LBSD_ACT_W-1:0]      i_s_tuser,   // action
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [lbsd_pkg::LBSD_OUT_DATA_W-1:0] o_m_tdata,   // serial_data, bit_index
    output logic                                 o_m_tlast    // latch_last
);
    import lbsd_pkg::*;

    t_frame_req  req, head;
    t_queue_stat q_stat;
    logic        pop;

    lbsd_front #(.NUM_LEDS(NUM_LEDS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_stat   (q_stat),
        .o_req      (req)
    );

    lbsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    lbsd_shifter #(.NUM_LEDS(NUM_LEDS)) u_shifter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    `LBSD_ASSERT_NEXT(a_frame_continues, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid && o_m_tdata[4:1] == $past(o_m_tdata[4:1]) + 4'd1, "frame broke off before its last word")
    `LBSD_ASSERT_NEXT(a_frame_starts_at_zero, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast, !o_m_tvalid || o_m_tdata[4:1] == 4'd0, "new frame does not start at led 0")
    `LBSD_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, q_stat.full, !req.valid, "frame request while queue full")

endmodule
